FILE: rtl/hlfa_pkg.sv
// Package: hole entry type, datapath command and status types, codes.
`timescale 1ns / 1ps
package hlfa_pkg;

  typedef struct packed {
    logic [15:0] size;
    logic [31:0] off;
  } hole_t;

  localparam logic       KIND_ALLOC = 1'b0;
  localparam logic       KIND_FREE  = 1'b1;

  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_BEST  = 2'd1;
  localparam logic [1:0] MODE_WORST = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [2:0] ST_HOLE     = 3'd0;
  localparam logic [2:0] ST_APPENDED = 3'd1;
  localparam logic [2:0] ST_RECORDED = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOSPACE  = 3'd4;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_FREE_SKIP,
    CMD_FREE_PUT,
    CMD_SCAN_START,
    CMD_SCAN_NEXT,
    CMD_TAKE,
    CMD_APPEND_END,
    CMD_WR_IDX,
    CMD_RM_RD,
    CMD_RM_WR,
    CMD_RM_END,
    CMD_SORT_INIT,
    CMD_SORT_RDKEY,
    CMD_SORT_LATCH,
    CMD_SORT_RDPREV,
    CMD_SORT_SHIFT,
    CMD_SORT_PUT,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    logic       is_free;
    logic       size_zero;
    logic       full;
    logic       count_zero;
    logic [1:0] mode;
    logic       hit;
    logic       scan_end;
    logic       left_zero;
    logic       rm_more;
    logic       sort_done;
    logic       j_zero;
    logic       ahead;
  } dp_stat_t;

endpackage

FILE: rtl/hlfa_req_if.sv
// Request channel: kind, region size and region offset.
`timescale 1ns / 1ps
interface hlfa_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] region_size;
  logic [31:0] region_offset;

  modport source (output valid, output kind, output region_size, output region_offset,
                  input ready);
  modport sink   (input valid, input kind, input region_size, input region_offset,
                  output ready);
endinterface

FILE: rtl/hlfa_rsp_if.sv
// Response channel: placed offset, status and hole count.
`timescale 1ns / 1ps
interface hlfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] placed_offset;
  logic [2:0]  status;
  logic [8:0]  holes_now;

  modport source (output valid, output placed_offset, output status, output holes_now,
                  input ready);
  modport sink   (input valid, input placed_offset, input status, input holes_now,
                  output ready);
endinterface

FILE: rtl/hlfa_datapath.sv
// Datapath: hole memory, counters, key and result registers.
`timescale 1ns / 1ps
module hlfa_datapath #(
  parameter int HOLE_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  hlfa_pkg::cmd_e    cmd_i,
  output hlfa_pkg::dp_stat_t stat_o,
  input  logic              kind_i,
  input  logic [15:0]       region_size_i,
  input  logic [31:0]       region_offset_i,
  output logic [31:0]       placed_offset_o,
  output logic [2:0]        status_o,
  output logic [8:0]        holes_now_o
);
  import hlfa_pkg::*;

  localparam int AW = (HOLE_DEPTH > 1) ? $clog2(HOLE_DEPTH) : 1;
  localparam int CW = $clog2(HOLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HOLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  hole_t mem [HOLE_DEPTH];
  hole_t rdata_q;

  logic [1:0]    fit_q;
  logic [1:0]    mode_q, mode_d;
  logic          kind_q, kind_d;
  logic [15:0]   size_q, size_d;
  logic [31:0]   off_q, off_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   endp_q, endp_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  hole_t         key_q, key_d;
  logic [31:0]   placed_q, placed_d;
  logic [2:0]    st_q, st_d;
  logic [31:0]   out_off_q, out_off_d;
  logic [2:0]    out_st_q, out_st_d;
  logic [8:0]    out_holes_q, out_holes_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  hole_t         wdata;
  logic [32:0]   endp_sum;
  logic [CW+8:0] count_ext;

  assign endp_sum  = {1'b0, endp_q} + {17'b0, size_q};
  assign count_ext = {9'b0, count_q};

  always_comb begin
    mode_d      = mode_q;
    kind_d      = kind_q;
    size_d      = size_q;
    off_d       = off_q;
    count_d     = count_q;
    endp_d      = endp_q;
    i_d         = i_q;
    j_d         = j_q;
    key_d       = key_q;
    placed_d    = placed_q;
    st_d        = st_q;
    out_off_d   = out_off_q;
    out_st_d    = out_st_q;
    out_holes_d = out_holes_q;
    we          = 1'b0;
    waddr       = i_q[AW-1:0];
    wdata       = key_q;
    raddr       = i_q[AW-1:0];
    case (cmd_i)
      CMD_LOAD: begin
        kind_d = kind_i;
        size_d = region_size_i;
        off_d  = region_offset_i;
        mode_d = (fit_q == MODE_SPARE) ? MODE_FIRST : fit_q;
      end
      CMD_FREE_SKIP: begin
        placed_d = off_q;
        st_d     = (size_q == 16'd0) ? ST_RECORDED : ST_FULL;
      end
      CMD_FREE_PUT: begin
        we       = 1'b1;
        waddr    = count_q[AW-1:0];
        wdata    = '{size: size_q, off: off_q};
        count_d  = count_q + ONE_C;
        placed_d = off_q;
        st_d     = ST_RECORDED;
      end
      CMD_SCAN_START: begin
        i_d   = (mode_q == MODE_BEST) ? count_q - ONE_C : '0;
        raddr = i_d[AW-1:0];
      end
      CMD_SCAN_NEXT: begin
        i_d   = (mode_q == MODE_BEST) ? i_q - ONE_C : i_q + ONE_C;
        raddr = i_d[AW-1:0];
      end
      CMD_TAKE: begin
        placed_d = rdata_q.off;
        key_d    = '{size: rdata_q.size - size_q, off: rdata_q.off + {16'b0, size_q}};
        st_d     = ST_HOLE;
      end
      CMD_APPEND_END: begin
        if (endp_sum[32]) begin
          placed_d = '0;
          st_d     = ST_NOSPACE;
        end else begin
          placed_d = endp_q;
          endp_d   = endp_sum[31:0];
          st_d     = ST_APPENDED;
        end
      end
      CMD_WR_IDX: begin
        we = 1'b1;
      end
      CMD_RM_RD: begin
        raddr = i_q[AW-1:0] + AW'(1);
      end
      CMD_RM_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
        i_d   = i_q + ONE_C;
      end
      CMD_RM_END: begin
        if (key_q.size != 16'd0) begin
          we    = 1'b1;
          waddr = count_q[AW-1:0] - AW'(1);
        end else begin
          count_d = count_q - ONE_C;
        end
      end
      CMD_SORT_INIT: begin
        i_d = ONE_C;
      end
      CMD_SORT_RDKEY: begin
        j_d = i_q;
      end
      CMD_SORT_LATCH: begin
        key_d = rdata_q;
      end
      CMD_SORT_RDPREV: begin
        raddr = j_q[AW-1:0] - AW'(1);
      end
      CMD_SORT_SHIFT: begin
        we    = 1'b1;
        waddr = j_q[AW-1:0];
        wdata = rdata_q;
        j_d   = j_q - ONE_C;
      end
      CMD_SORT_PUT: begin
        we    = 1'b1;
        waddr = j_q[AW-1:0];
        i_d   = i_q + ONE_C;
      end
      CMD_EMIT: begin
        out_off_d   = placed_q;
        out_st_d    = st_q;
        out_holes_d = count_ext[8:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.is_free    = (kind_q == KIND_FREE);
    stat_o.size_zero  = (size_q == 16'd0);
    stat_o.full       = (count_q >= DEPTH_C);
    stat_o.count_zero = (count_q == '0);
    stat_o.mode       = mode_q;
    stat_o.hit        = (rdata_q.size >= size_q);
    stat_o.scan_end   = (mode_q == MODE_BEST) ? (i_q == '0) : (i_q + ONE_C == count_q);
    stat_o.left_zero  = (key_q.size == 16'd0);
    stat_o.rm_more    = ({1'b0, i_q} + {{CW{1'b0}}, 1'b1}) < {1'b0, count_q};
    stat_o.sort_done  = (i_q >= count_q);
    stat_o.j_zero     = (j_q == '0);
    if (key_q.size != rdata_q.size) begin
      stat_o.ahead = key_q.size > rdata_q.size;
    end else if (mode_q == MODE_WORST) begin
      stat_o.ahead = key_q.off < rdata_q.off;
    end else begin
      stat_o.ahead = key_q.off > rdata_q.off;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q   <= MODE_FIRST;
      count_q <= '0;
      endp_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        fit_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      endp_q  <= endp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    kind_q      <= kind_d;
    size_q      <= size_d;
    off_q       <= off_d;
    i_q         <= i_d;
    j_q         <= j_d;
    key_q       <= key_d;
    placed_q    <= placed_d;
    st_q        <= st_d;
    out_off_q   <= out_off_d;
    out_st_q    <= out_st_d;
    out_holes_q <= out_holes_d;
  end

  assign placed_offset_o = out_off_q;
  assign status_o        = out_st_q;
  assign holes_now_o     = out_holes_q;

endmodule

FILE: rtl/hlfa_ctrl.sv
// Controller: sequences scan, removal and insertion sort over the hole memory.
`timescale 1ns / 1ps
module hlfa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  hlfa_pkg::dp_stat_t stat_i,
  output hlfa_pkg::cmd_e     cmd_o
);
  import hlfa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_NOFIT, S_TAKE, S_RM_RD, S_RM_WR, S_RM_END,
    S_SORT_INIT, S_SORT_OUTER, S_SORT_KEY, S_SORT_INNER, S_SORT_CMP, S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    in_ready_d  = in_ready_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o      = CMD_LOAD;
          in_ready_d = 1'b0;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.is_free) begin
          if (stat_i.size_zero || stat_i.full) begin
            cmd_o   = CMD_FREE_SKIP;
            state_d = S_EMIT;
          end else begin
            cmd_o   = CMD_FREE_PUT;
            state_d = (stat_i.mode == MODE_FIRST) ? S_EMIT : S_SORT_INIT;
          end
        end else if (stat_i.count_zero) begin
          state_d = S_NOFIT;
        end else begin
          cmd_o   = CMD_SCAN_START;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o   = CMD_TAKE;
          state_d = S_TAKE;
        end else if (stat_i.scan_end) begin
          state_d = S_NOFIT;
        end else begin
          cmd_o = CMD_SCAN_NEXT;
        end
      end
      S_NOFIT: begin
        cmd_o   = CMD_APPEND_END;
        state_d = S_EMIT;
      end
      S_TAKE: begin
        if (stat_i.mode == MODE_FIRST || stat_i.left_zero) begin
          state_d = S_RM_RD;
        end else begin
          cmd_o   = CMD_WR_IDX;
          state_d = S_SORT_INIT;
        end
      end
      S_RM_RD: begin
        if (stat_i.rm_more) begin
          cmd_o   = CMD_RM_RD;
          state_d = S_RM_WR;
        end else begin
          state_d = S_RM_END;
        end
      end
      S_RM_WR: begin
        cmd_o   = CMD_RM_WR;
        state_d = S_RM_RD;
      end
      S_RM_END: begin
        cmd_o   = CMD_RM_END;
        state_d = (stat_i.mode == MODE_FIRST) ? S_EMIT : S_SORT_INIT;
      end
      S_SORT_INIT: begin
        cmd_o   = CMD_SORT_INIT;
        state_d = S_SORT_OUTER;
      end
      S_SORT_OUTER: begin
        if (stat_i.sort_done) begin
          state_d = S_EMIT;
        end else begin
          cmd_o   = CMD_SORT_RDKEY;
          state_d = S_SORT_KEY;
        end
      end
      S_SORT_KEY: begin
        cmd_o   = CMD_SORT_LATCH;
        state_d = S_SORT_INNER;
      end
      S_SORT_INNER: begin
        if (stat_i.j_zero) begin
          cmd_o   = CMD_SORT_PUT;
          state_d = S_SORT_OUTER;
        end else begin
          cmd_o   = CMD_SORT_RDPREV;
          state_d = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        if (stat_i.ahead) begin
          cmd_o   = CMD_SORT_SHIFT;
          state_d = S_SORT_INNER;
        end else begin
          cmd_o   = CMD_SORT_PUT;
          state_d = S_SORT_OUTER;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_EMIT;
          out_valid_d = 1'b1;
          in_ready_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_ready_q  <= in_ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/hole_list_fit_allocator.sv
// Top level: free-hole list allocator with first, best and worst fit.
//
// One request is in flight at a time; its result sits in an output register
// so the next request is taken while that beat waits. Holes live in a memory
// of HOLE_DEPTH entries with a write port and a registered read port (one
// write, one registered read a cycle), and those ports set the timing. A free
// in first fit loads the request, writes the hole and emits the result. An
// allocate scans one entry a cycle; then, unless best or worst fit keeps a
// remainder in place, each entry behind the chosen one moves down one place.
// In best and worst fit every change is followed by an insertion sort that
// shifts up the earlier entries ranked behind each key. The memory needs no
// clearing pass; hole count, end pointer and fit mode reset to zero.
`timescale 1ns / 1ps
module hole_list_fit_allocator #(
  parameter int HOLE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  hlfa_req_if.sink   req_i,
  hlfa_rsp_if.source rsp_o
);
  import hlfa_pkg::*;

  cmd_e     cmd;
  dp_stat_t stat;

  hlfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  hlfa_datapath #(
    .HOLE_DEPTH (HOLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (req_i.kind),
    .region_size_i   (req_i.region_size),
    .region_offset_i (req_i.region_offset),
    .placed_offset_o (rsp_o.placed_offset),
    .status_o        (rsp_o.status),
    .holes_now_o     (rsp_o.holes_now)
  );

endmodule
